// File: rtl/hec_pkg.sv
// shared types, codes and character helpers for the name hex escape codec
// no dependencies; imported by the core, front, queue and back modules
package hec_pkg;

   localparam logic [1:0] MODE_PATH     = 2'd0;
   localparam logic [1:0] MODE_MANGLE   = 2'd1;
   localparam logic [1:0] MODE_UNESCAPE = 2'd2;

   localparam logic [1:0] REG_CODEC_MODE   = 2'd0;
   localparam logic [1:0] REG_GLOB_ALLOWED = 2'd1;

   localparam logic [7:0] CHR_SLASH     = 8'h2f;
   localparam logic [7:0] CHR_DASH      = 8'h2d;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHR_DOT       = 8'h2e;
   localparam logic [7:0] CHR_X         = 8'h78;
   localparam logic [7:0] CHR_COLON     = 8'h3a;
   localparam logic [7:0] CHR_UNDER     = 8'h5f;
   localparam logic [7:0] CHR_AT        = 8'h40;
   localparam logic [7:0] CHR_LBRACKET  = 8'h5b;
   localparam logic [7:0] CHR_RBRACKET  = 8'h5d;
   localparam logic [7:0] CHR_BANG      = 8'h21;
   localparam logic [7:0] CHR_STAR      = 8'h2a;
   localparam logic [7:0] CHR_QUESTION  = 8'h3f;

   typedef enum logic {
      OP_BYTE,
      OP_ESCAPE
   } hec_op_type;

   typedef struct packed {
      hec_op_type op;
      logic [7:0] data;
      logic       changed;
      logic       error;
      logic       last;
   } hec_entry_type;

   typedef struct packed {
      logic          valid;
      hec_entry_type entry;
   } hec_push_type;

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7a) ||
             (c >= 8'h41 && c <= 8'h5a);
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
         return {1'b1, v[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
         return {1'b1, v[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
         return {1'b1, v[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + {4'd0, v};
      end
      return 8'h57 + {4'd0, v};
   endfunction

endpackage

// File: rtl/hec_ifs.sv
// request, response and register write channel interfaces of the codec
// no dependencies
interface hec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   modport source (output valid, in_byte, in_last, input ready);
   modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface hec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic       out_changed;
   logic       out_error;
   modport source (output valid, out_byte, out_last, out_changed, out_error, input ready);
   modport sink (input valid, out_byte, out_last, out_changed, out_error, output ready);
endinterface

interface hec_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/name_hex_escape_codec_core.sv
// top level of the name hex escape codec: front end, command queue, back end
// depends on hec_pkg, hec_ifs, hec_front, hec_queue and hec_back
//
// req_chan takes one character a cycle unless the queue is full (in_byte,
// in_last marks the end of a string); rsp_chan returns the produced characters
// with out_last, out_changed and out_error. csr_chan writes codec_mode
// (index 0) and glob_allowed (index 1) and is always ready; write it only while
// no string is in flight. A request is classified in the cycle it is accepted
// and queued as one command, or in unescape mode as none while an escape is
// collected or after an error. The back end turns a command into one response,
// or four for an escaped byte. Throughput is one request a cycle while each
// request gives one response; an escaped byte occupies the back end for four
// responses, and the queue of QUEUE_DEPTH commands then fills and req_chan.ready
// drops. A stalled rsp_chan holds its output register; the front end keeps
// accepting until the queue is full. Reset clears the registers to path escape
// with glob characters escaped and empties the queue; no clearing pass.
module name_hex_escape_codec_core
   import hec_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   hec_req_if.sink     req_chan,
   hec_rsp_if.source   rsp_chan,
   hec_csr_if.sink     csr_chan
);

   hec_push_type  push;
   hec_entry_type head;
   logic          q_full;
   logic          q_empty;
   logic          pop;

   hec_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_full   (q_full),
      .push     (push)
   );

   hec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .empty (q_empty),
      .head  (head)
   );

   hec_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: rtl/hec_front.sv
// front end: register file, byte classification and unescape state machine
// depends on hec_pkg and hec_ifs; pushes commands into hec_queue
module hec_front
   import hec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   hec_req_if.sink      req_chan,
   hec_csr_if.sink      csr_chan,
   input  logic         q_full,
   output hec_push_type push
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BACKSLASH,
      PH_X,
      PH_HIGH
   } phase_type;

   logic [1:0] mode_ff;
   logic       glob_ff;
   logic       at_start_ff, at_start_in;
   phase_type  phase_ff, phase_in;
   logic [3:0] high_ff, high_in;
   logic       error_seen_ff, error_seen_in;
   logic       accept;

   assign req_chan.ready = !q_full;
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && !q_full;

   always_comb begin
      logic [7:0] c;
      logic       last;
      logic       keep;
      logic       err;
      logic [4:0] hv;
      c = req_chan.in_byte;
      last = req_chan.in_last;
      keep = 1'b0;
      err = 1'b0;
      hv = hex_value(c);
      at_start_in = at_start_ff;
      phase_in = phase_ff;
      high_in = high_ff;
      error_seen_in = error_seen_ff;
      push = '0;
      if (accept) begin
         if (error_seen_ff) begin
            if (last) begin
               at_start_in = 1'b1;
               phase_in = PH_IDLE;
               high_in = 4'd0;
               error_seen_in = 1'b0;
            end
         end else begin
            at_start_in = 1'b0;
            if (mode_ff == MODE_PATH || mode_ff == MODE_MANGLE) begin
               phase_in = PH_IDLE;
               if (mode_ff == MODE_PATH) begin
                  keep = !(at_start_ff && c == CHR_DOT) &&
                         (is_alnum(c) || c == CHR_COLON || c == CHR_UNDER || c == CHR_DOT);
               end else begin
                  keep = is_alnum(c) || c == CHR_COLON || c == CHR_DASH ||
                         c == CHR_UNDER || c == CHR_DOT || c == CHR_BACKSLASH ||
                         c == CHR_AT ||
                         (glob_ff && (c == CHR_LBRACKET || c == CHR_RBRACKET ||
                                      c == CHR_BANG || c == CHR_STAR ||
                                      c == CHR_QUESTION));
               end
               push.valid = 1'b1;
               push.entry.last = last;
               push.entry.error = 1'b0;
               if (c == CHR_SLASH) begin
                  push.entry.op = OP_BYTE;
                  push.entry.data = CHR_DASH;
                  push.entry.changed = 1'b1;
               end else if (keep) begin
                  push.entry.op = OP_BYTE;
                  push.entry.data = c;
                  push.entry.changed = 1'b0;
               end else begin
                  push.entry.op = OP_ESCAPE;
                  push.entry.data = c;
                  push.entry.changed = 1'b1;
               end
            end else begin
               push.entry.op = OP_BYTE;
               push.entry.last = last;
               push.entry.error = 1'b0;
               unique case (phase_ff)
                  PH_BACKSLASH: begin
                     if (c == CHR_X) phase_in = PH_X;
                     else err = 1'b1;
                  end
                  PH_X: begin
                     if (!hv[4]) begin
                        err = 1'b1;
                     end else begin
                        high_in = hv[3:0];
                        phase_in = PH_HIGH;
                     end
                  end
                  PH_HIGH: begin
                     if (!hv[4]) begin
                        err = 1'b1;
                     end else begin
                        push.valid = 1'b1;
                        push.entry.data = {high_ff, hv[3:0]};
                        push.entry.changed = 1'b1;
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_IDLE: begin
                     if (c == CHR_DASH) begin
                        push.valid = 1'b1;
                        push.entry.data = CHR_SLASH;
                        push.entry.changed = 1'b1;
                     end else if (c == CHR_BACKSLASH) begin
                        phase_in = PH_BACKSLASH;
                     end else begin
                        push.valid = 1'b1;
                        push.entry.data = c;
                        push.entry.changed = 1'b0;
                     end
                  end
                  default: ;
               endcase
               if (last && phase_in != PH_IDLE) err = 1'b1;
               if (err) begin
                  push.valid = 1'b1;
                  push.entry.data = 8'h00;
                  push.entry.changed = 1'b0;
                  push.entry.error = 1'b1;
                  push.entry.last = 1'b1;
                  error_seen_in = !last;
                  phase_in = PH_IDLE;
                  high_in = 4'd0;
               end
            end
            if (last) begin
               at_start_in = 1'b1;
               phase_in = PH_IDLE;
               high_in = 4'd0;
               error_seen_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PATH;
         glob_ff <= 1'b0;
         at_start_ff <= 1'b1;
         phase_ff <= PH_IDLE;
         high_ff <= 4'd0;
         error_seen_ff <= 1'b0;
      end else begin
         at_start_ff <= at_start_in;
         phase_ff <= phase_in;
         high_ff <= high_in;
         error_seen_ff <= error_seen_in;
         if (csr_chan.valid) begin
            case (csr_chan.index)
               REG_CODEC_MODE:   mode_ff <= csr_chan.data;
               REG_GLOB_ALLOWED: glob_ff <= csr_chan.data[0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: rtl/hec_queue.sv
// command queue between front end and back end
// depends on hec_pkg
module hec_queue
   import hec_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  hec_push_type  push,
   input  logic          pop,
   output logic          full,
   output logic          empty,
   output hec_entry_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   hec_entry_type      slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) count_in = count_ff + 1'b1;
      else if (!push.valid && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) slot_ff[wr_ptr_ff] <= push.entry;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !pop && !$past(reset)) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

// File: rtl/hec_back.sv
// back end: expands queued commands into response bytes, holds the output register
// depends on hec_pkg and hec_ifs; pops from hec_queue
module hec_back
   import hec_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  hec_entry_type head,
   output logic          pop,
   hec_rsp_if.source     rsp_chan
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] beat_ff, beat_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       changed_ff, changed_in;
   logic       error_ff, error_in;
   logic       load;
   logic       beat_last;

   assign load = (!rsp_valid_ff || rsp_chan.ready) && !q_empty;
   assign beat_last = (head.op == OP_BYTE) || (beat_ff == 2'd3);
   assign pop = load && beat_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      beat_in = beat_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         beat_in = beat_last ? 2'd0 : beat_ff + 2'd1;
      end
      if (head.op == OP_BYTE) begin
         byte_in = head.data;
      end else begin
         case (beat_ff)
            2'd0:    byte_in = CHR_BACKSLASH;
            2'd1:    byte_in = CHR_X;
            2'd2:    byte_in = hex_digit(head.data[7:4]);
            default: byte_in = hex_digit(head.data[3:0]);
         endcase
      end
      changed_in = (head.op == OP_ESCAPE) || head.changed;
      error_in = (head.op == OP_BYTE) && head.error;
      last_in = head.last && beat_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         beat_ff <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         changed_ff <= changed_in;
         error_ff <= error_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_byte = byte_ff;
   assign rsp_chan.out_last = last_ff;
   assign rsp_chan.out_changed = changed_ff;
   assign rsp_chan.out_error = error_ff;

endmodule
